/* src/b64e_pkg.sv */
package b64e_pkg;

    // Symbol carried from the front to the back: a pad flag over a sextet.
    localparam int SYM_W = 7;
    localparam int MAX_CHARS = 4;
    localparam int IDX_W = 2;

    // Depth of the transaction queue between the front and the back.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic [SYM_W-1:0] PAD_SYM = 7'h40;

    typedef logic [SYM_W-1:0] sym_t;

    // One queued job: the characters caused by one input byte.
    typedef struct packed {
        sym_t [MAX_CHARS-1:0] syms;
        logic [IDX_W-1:0]     last_idx;
        logic                 eom;
    } job_t;

    // Map a symbol onto its ASCII code in the standard alphabet.
    function automatic logic [7:0] sym_to_ascii(input sym_t sym);
        logic [7:0] v;
        v = {2'b00, sym[5:0]};
        if (sym[6])
            return PAD_CHAR;
        else if (v < 8'd26)
            return 8'h41 + v;
        else if (v < 8'd52)
            return 8'h61 + (v - 8'd26);
        else if (v < 8'd62)
            return 8'h30 + (v - 8'd52);
        else if (v == 8'd62)
            return 8'h2B;
        else
            return 8'h2F;
    endfunction

endpackage

/* src/b64e_front.sv */
module b64e_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       data_byte,
    input  logic             end_of_message,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             push_valid,
    input  logic             push_ready,
    output b64e_pkg::job_t   push_job
);

    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [3:0] carry_reg, carry_next;
    logic       accept;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    // Classify the byte by its group position and build its job.
    always_comb
    begin
        push_job = '0;
        push_job.eom = end_of_message;
        phase_next = phase_reg;
        carry_next = carry_reg;
        unique case (phase_reg)
            PH_1:
            begin
                push_job.syms[0] = {1'b0, carry_reg[1:0], data_byte[7:4]};
                carry_next = data_byte[3:0];
                phase_next = PH_2;
                if (end_of_message)
                begin
                    push_job.syms[1] = {1'b0, data_byte[3:0], 2'b00};
                    push_job.syms[2] = b64e_pkg::PAD_SYM;
                    push_job.last_idx = 2'd2;
                end
            end
            PH_2:
            begin
                push_job.syms[0] = {1'b0, carry_reg[3:0], data_byte[7:6]};
                push_job.syms[1] = {1'b0, data_byte[5:0]};
                push_job.last_idx = 2'd1;
                carry_next = 4'd0;
                phase_next = PH_0;
            end
            default:
            begin
                push_job.syms[0] = {1'b0, data_byte[7:2]};
                carry_next = {2'b00, data_byte[1:0]};
                phase_next = PH_1;
                if (end_of_message)
                begin
                    push_job.syms[1] = {1'b0, data_byte[1:0], 4'b0000};
                    push_job.syms[2] = b64e_pkg::PAD_SYM;
                    push_job.syms[3] = b64e_pkg::PAD_SYM;
                    push_job.last_idx = 2'd3;
                end
            end
        endcase
        // The last byte returns the encoder to the start of a group.
        if (end_of_message)
        begin
            phase_next = PH_0;
            carry_next = 4'd0;
        end
    end

    // Group position and leftover bits advance on each accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_0;
            carry_reg <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

/* src/b64e_fifo.sv */
module b64e_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  b64e_pkg::job_t wr_job,
    output logic           rd_valid,
    input  logic           rd_ready,
    output b64e_pkg::job_t rd_job
);

    b64e_pkg::job_t                  entry_reg [b64e_pkg::FIFO_DEPTH];
    logic [b64e_pkg::FIFO_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [b64e_pkg::FIFO_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [b64e_pkg::FIFO_CW-1:0]    count_reg, count_next;
    logic                            do_wr, do_rd;

    assign wr_ready = (count_reg != b64e_pkg::FIFO_CW'(b64e_pkg::FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == b64e_pkg::FIFO_AW'(b64e_pkg::FIFO_DEPTH - 1))
                ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == b64e_pkg::FIFO_AW'(b64e_pkg::FIFO_DEPTH - 1))
                ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

/* src/b64e_back.sv */
module b64e_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  b64e_pkg::job_t pop_job,
    output logic [7:0]     out_char,
    output logic           final_char,
    output logic           out_valid,
    input  logic           out_ready
);

    b64e_pkg::job_t                job_reg;
    logic                          job_valid_reg, job_valid_next;
    logic [b64e_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [7:0]                    char_reg, char_next;
    logic                          final_reg, final_next;
    logic                          ovalid_reg, ovalid_next;
    logic                          load_ok, load, job_done;

    assign out_char   = char_reg;
    assign final_char = final_reg;
    assign out_valid  = ovalid_reg;

    // The output register takes a character whenever it is empty or being drained and a job is held.
    assign load_ok   = !ovalid_reg || out_ready;
    assign load      = load_ok && job_valid_reg;
    assign job_done  = load && (idx_reg == job_reg.last_idx);
    assign pop_ready = !job_valid_reg || job_done;

    always_comb
    begin
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        char_next      = char_reg;
        final_next     = final_reg;
        ovalid_next    = ovalid_reg;
        if (load_ok)
            ovalid_next = job_valid_reg;
        if (load)
        begin
            char_next  = b64e_pkg::sym_to_ascii(job_reg.syms[idx_reg]);
            final_next = job_reg.eom && (idx_reg == job_reg.last_idx);
            idx_next   = idx_reg + 1'b1;
        end
        if (pop_ready)
        begin
            job_valid_next = pop_valid;
            idx_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            ovalid_reg    <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            ovalid_reg    <= ovalid_next;
        end
    end

    // Current job and output character are payload.
    always_ff @(posedge clk)
    begin
        if (pop_ready && pop_valid)
            job_reg <= pop_job;
        char_reg  <= char_next;
        final_reg <= final_next;
    end

endmodule

/* src/base64_stream_encoder_top.sv */
// A byte's first character moves through the queue, the job register and the output register.
// Throughput: one character per cycle while out_ready holds, set by the single output register; a
// byte yields one to four characters, so sustained input is one byte per cycle only as they drain.
// A two-entry queue between the byte classifier and the character emitter absorbs stalls.
// Reset (rst_n, asynchronous, active low) empties the queue and output and restarts the group.
module base64_stream_encoder_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       end_of_message,
    input  logic       in_valid,
    output logic       in_ready,
    output logic [7:0] out_char,
    output logic       final_char,
    output logic       out_valid,
    input  logic       out_ready
);

    logic           push_valid, push_ready;
    b64e_pkg::job_t push_job;
    logic           pop_valid, pop_ready;
    b64e_pkg::job_t pop_job;

    // Byte classification and group tracking.
    b64e_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_job       (push_job)
    );

    // Job queue between the two halves.
    b64e_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_job   (push_job),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_job   (pop_job)
    );

    // Character emission, one per cycle while out_ready holds.
    b64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job),
        .out_char   (out_char),
        .final_char (final_char),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

endmodule

/* src/b64e_checker.sv */
module b64e_checker (
    input logic       clk,
    input logic       rst_n,
    input logic [7:0] data_byte,
    input logic       end_of_message,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] out_char,
    input logic       final_char,
    input logic       out_valid,
    input logic       out_ready
);

    // A waiting input transaction holds its payload until it is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(data_byte) && $stable(end_of_message))
        else $error("waiting input changed");

    // A stalled result transaction holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(final_char))
        else $error("stalled output changed");

    // Every character is from the standard alphabet or is the pad.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_char >= 8'h41 && out_char <= 8'h5A) ||
                      (out_char >= 8'h61 && out_char <= 8'h7A) ||
                      (out_char >= 8'h30 && out_char <= 8'h39) ||
                      out_char == 8'h2B || out_char == 8'h2F || out_char == 8'h3D)
        else $error("character outside the alphabet");

    // A pad that does not end the message is followed at once by the final pad.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_char == 8'h3D && !final_char |=>
            out_valid && out_char == 8'h3D && final_char)
        else $error("first pad not followed by final pad");

endmodule

bind base64_stream_encoder_top b64e_checker u_b64e_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_char       (out_char),
    .final_char     (final_char),
    .out_valid      (out_valid),
    .out_ready      (out_ready)
);

/* dv/tb_base64_stream_encoder_top.sv */
`timescale 1ns / 100ps

module tb_base64_stream_encoder_top;

    // Scoreboard: tracks the group position and leftover bits of the stream
    // and holds the characters still owed by the encoder.
    class b64_scoreboard;
        string      digits = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ",
                              "abcdefghijklmnopqrstuvwxyz0123456789+/"};
        logic [7:0] owed_chars[$];
        logic       owed_final[$];
        bit [1:0]   phase;
        bit [3:0]   carry;
        int         errors;
        int         chars_seen;
        int         bytes_seen;
        int         messages_seen;

        function new();
            phase = 2'd0;
            carry = 4'd0;
            errors = 0;
            chars_seen = 0;
            bytes_seen = 0;
            messages_seen = 0;
        endfunction

        function int pending();
            return owed_chars.size();
        endfunction

        function void owe_char(logic [7:0] ch);
            owed_chars.push_back(ch);
            owed_final.push_back(1'b0);
        endfunction

        function void owe_sextet(bit [5:0] s);
            owe_char(digits[s]);
        endfunction

        // Work out the characters that one accepted byte completes.
        function void note_byte(logic [7:0] b, logic eom);
            bytes_seen++;
            case (phase)
                2'd1:
                begin
                    owe_sextet({carry[1:0], b[7:4]});
                    carry = b[3:0];
                    phase = 2'd2;
                    if (eom)
                    begin
                        owe_sextet({b[3:0], 2'b00});
                        owe_char(b64e_pkg::PAD_CHAR);
                    end
                end
                2'd2:
                begin
                    owe_sextet({carry, b[7:6]});
                    owe_sextet(b[5:0]);
                    carry = 4'd0;
                    phase = 2'd0;
                end
                default:
                begin
                    // The unused fourth position behaves as a group start.
                    owe_sextet(b[7:2]);
                    carry = {2'b00, b[1:0]};
                    phase = 2'd1;
                    if (eom)
                    begin
                        owe_sextet({b[1:0], 4'b0000});
                        owe_char(b64e_pkg::PAD_CHAR);
                        owe_char(b64e_pkg::PAD_CHAR);
                    end
                end
            endcase
            // The end of a message flags its last character and restarts the group.
            if (eom)
            begin
                owed_final[owed_final.size() - 1] = 1'b1;
                phase = 2'd0;
                carry = 4'd0;
                messages_seen++;
            end
        endfunction

        task report_mismatch(string what);
            $display("%0t: mismatch: %s", $time, what);
            errors++;
        endtask

        // Compare one accepted character with the oldest one owed.
        task check_char(logic [7:0] ch, logic fin);
            logic [7:0] want_char;
            logic       want_final;
            chars_seen++;
            if (owed_chars.size() == 0)
            begin
                report_mismatch($sformatf("unexpected char 0x%02h final %b", ch, fin));
            end
            else
            begin
                want_char = owed_chars.pop_front();
                want_final = owed_final.pop_front();
                if (ch !== want_char)
                    report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                              ch, want_char));
                if (fin !== want_final)
                    report_mismatch($sformatf("final_char %b, expected %b on char 0x%02h",
                                              fin, want_final, want_char));
            end
        endtask
    endclass

    localparam int STALL_PCT = 13;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_BYTES = 175;
    localparam int DIRECTED_LEN = 21;

    logic       clk;
    logic       rst_n;
    logic [7:0] data_byte;
    logic       end_of_message;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] out_char;
    logic       final_char;
    logic       out_valid;
    logic       out_ready;

    b64_scoreboard sb;
    bit            no_stalls;
    int            quiet_cycles;

    // Directed messages: single bytes at both extremes, two-byte messages,
    // full groups including the top alphabet entries, and longer messages
    // ending one and two bytes into a group.
    logic [7:0] directed_bytes [DIRECTED_LEN] = '{
        8'h00,
        8'hFF,
        8'hFF, 8'h00,
        8'h00, 8'hFF,
        8'hFF, 8'hFF, 8'hFF,
        8'h00, 8'h00, 8'h00,
        8'hFB, 8'hEF, 8'hBE, 8'hA5,
        8'h4D, 8'h61, 8'h6E, 8'h2A, 8'h10
    };
    bit directed_eom [DIRECTED_LEN] = '{
        1,
        1,
        0, 1,
        0, 1,
        0, 0, 1,
        0, 0, 1,
        0, 0, 0, 1,
        0, 0, 0, 0, 1
    };

    base64_stream_encoder_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .out_char       (out_char),
        .final_char     (final_char),
        .out_valid      (out_valid),
        .out_ready      (out_ready)
    );

    always #10 clk = ~clk;

    // Output side: the receiver stalls at random except in the quiet stretch.
    always @(posedge clk)
    begin
        out_ready <= no_stalls || ($urandom_range(99) >= STALL_PCT);
    end

    // Monitor: records every input transaction, checks every output
    // transaction, and ends the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_byte(data_byte, end_of_message);
            if (out_valid && out_ready)
                sb.check_char(out_char, final_char);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    // Offer one byte, idling first at random, and return once it is accepted.
    task send_byte(input logic [7:0] b, input logic eom);
        while (!no_stalls && ($urandom_range(99) < STALL_PCT))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        end_of_message <= eom;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task send_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), i == len - 1);
    endtask

    // Hold the sender back until every owed character has come out.
    // The first edge lets the monitor record the byte accepted last.
    task wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int  len;
        bit  paused;
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        end_of_message = 1'b0;
        out_ready = 1'b0;
        no_stalls = 1'b0;
        quiet_cycles = 0;
        paused = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_LEN; i++)
            send_byte(directed_bytes[i], directed_eom[i]);
        wait_drained();

        // Random messages, mostly short, now and then a long one.
        while (sb.bytes_seen < DIRECTED_LEN + RANDOM_BYTES)
        begin
            no_stalls = (sb.bytes_seen > 90) && (sb.bytes_seen < 140);
            if (!paused && sb.bytes_seen > 160)
            begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(9) == 0)
                len = $urandom_range(20, 7);
            else
                len = $urandom_range(6, 1);
            send_message(len);
        end
        no_stalls = 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);

        $display("Encoded %0d bytes in %0d messages into %0d characters.",
                 sb.bytes_seen, sb.messages_seen, sb.chars_seen);
        $display("Messages ended at every group position; both sides stalled at random.");
        if (sb.errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("%0d mismatches", sb.errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
